### sv/uplink_frame_validator_defines.svh
// Assertion macros shared by the frame validator.
// Depends on nothing; the including module supplies clock and reset.
`ifndef UPLINK_FRAME_VALIDATOR_DEFINES_SVH
`define UPLINK_FRAME_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UFV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UFV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ufv_pkg.sv
// Shared types, constants and helper functions of the frame validator.
// Used by every module of the block; depends on nothing.
package ufv_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 1024;
   localparam int unsigned COUNT_W         = 32;
   localparam int unsigned TOTAL_W         = 32;
   localparam int unsigned LEN_W           = 11;
   localparam int unsigned PAD_UNIT        = 8;
   localparam int unsigned WORD_BYTES      = 2;
   localparam int unsigned PADDR_W         = 4;
   localparam int unsigned PDATA_W         = 32;
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] RESET_EXPECTED_LENGTH = LEN_W'(86);
   localparam logic [LEN_W-1:0] RESET_PAYLOAD_LIMIT   = LEN_W'(256);

   typedef enum logic [2:0] {
      VERDICT_GOOD_CHECKED   = 3'd0,
      VERDICT_GOOD_UNCHECKED = 3'd1,
      VERDICT_NO_PREAMBLE    = 3'd2,
      VERDICT_BAD_LENGTH     = 3'd3,
      VERDICT_LEN_MISMATCH   = 3'd4,
      VERDICT_BAD_CHECKSUM   = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      REG_CHECK_ENABLE    = 2'd0,
      REG_EXPECTED_LENGTH = 2'd1,
      REG_PAYLOAD_LIMIT   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic             check_enable;
      logic [LEN_W-1:0] expected_length;
      logic [LEN_W-1:0] payload_limit;
   } cfg_type;

   // Summary of one finished frame, handed from the front to the back.
   typedef struct packed {
      logic [LEN_W-1:0] frame_length;
      logic             xor_zero;
      logic             preamble;
   } frame_sum_type;

   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

   // Payload limit saturated at the largest frame the block supports.
   function automatic logic [LEN_W-1:0] eff_limit(input logic [LEN_W-1:0] limit);
      logic [LEN_W-1:0] max_len;
      max_len = LEN_W'(MAX_FRAME_BYTES);
      return (limit > max_len) ? max_len : limit;
   endfunction

endpackage

### sv/uplink_frame_validator.sv
// Top level of the uplink frame validator: register port, front, queue, back.
// Depends on ufv_pkg, ufv_front, ufv_queue, ufv_back and the defines header.
//
// Usage: frame bytes enter on the req_ channel, one item per byte, with
// req_last_byte marking the final byte and req_preamble_valid sampled there.
// Each frame yields exactly one item on the rsp_ channel, issued after its
// final byte: a verdict, the kept and padded lengths, and the frame counters
// as they stand after that frame. Bytes that are not final yield nothing.
// Throughput is one byte per cycle while req_stall is low; the running XOR
// and byte count in the front are registered as each byte is accepted. The
// frame summary is written into the queue at the edge that accepts the
// final byte and moves from there into the result register, raising
// rsp_valid, once that register is free. A four-entry queue of frame
// summaries separates the front from the back; req_stall rises only when
// that queue is full, which happens only after the receiver has stalled rsp_
// long enough for four summaries to back up behind the held result. A
// stalled result holds steady.
// Reset is synchronous: it empties the queue, clears the per-frame state and
// all counters, and loads the registers with check_enable 1, expected_length
// 86 and payload_limit 256. Registers sit at byte addresses 0, 4 and 8 and
// should be written only while no frame is in flight.
`include "uplink_frame_validator_defines.svh"
module uplink_frame_validator import ufv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   input  logic               req_preamble_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_verdict,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic [LEN_W-1:0]   rsp_padded_length,
   output logic [TOTAL_W-1:0] rsp_received_total,
   output logic [TOTAL_W-1:0] rsp_good_total,
   output logic [TOTAL_W-1:0] rsp_bad_total,
   output logic [TOTAL_W-1:0] rsp_bad_length_total,
   output logic [TOTAL_W-1:0] rsp_bad_checksum_total,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type          cfg_ff;
   logic             cfg_write;
   reg_index_type    reg_index;
   logic             req_accept;
   logic             push;
   frame_sum_type    push_data;
   frame_sum_type    head;
   queue_status_type queue_status;
   logic             pop;
   verdict_type      verdict;

   // Register port. Every access completes in its access cycle.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_enable    <= 1'b1;
         cfg_ff.expected_length <= RESET_EXPECTED_LENGTH;
         cfg_ff.payload_limit   <= RESET_PAYLOAD_LIMIT;
      end else if (cfg_write) begin
         case (reg_index)
            REG_CHECK_ENABLE:    cfg_ff.check_enable    <= pwdata[0];
            REG_EXPECTED_LENGTH: cfg_ff.expected_length <= pwdata[LEN_W-1:0];
            REG_PAYLOAD_LIMIT:   cfg_ff.payload_limit   <= pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reads of unused addresses return zero.
   always_comb begin
      case (reg_index)
         REG_CHECK_ENABLE:    prdata = PDATA_W'(cfg_ff.check_enable);
         REG_EXPECTED_LENGTH: prdata = PDATA_W'(cfg_ff.expected_length);
         REG_PAYLOAD_LIMIT:   prdata = PDATA_W'(cfg_ff.payload_limit);
         default:             prdata = '0;
      endcase
   end

   // The front only stalls when the summary queue has no room left.
   assign req_stall  = queue_status.full;
   assign req_accept = req_valid && !req_stall;

   ufv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .preamble_valid (req_preamble_valid),
      .push           (push),
      .push_data      (push_data)
   );

   ufv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   ufv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head               (head),
      .head_valid         (queue_status.head_valid),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .verdict            (verdict),
      .frame_length       (rsp_frame_length),
      .padded_length      (rsp_padded_length),
      .received_total     (rsp_received_total),
      .good_total         (rsp_good_total),
      .bad_total          (rsp_bad_total),
      .bad_length_total   (rsp_bad_length_total),
      .bad_checksum_total (rsp_bad_checksum_total)
   );

   assign rsp_verdict = verdict;

   // Every counted frame is either good or bad, and every bad frame is
   // blamed on exactly one cause.
   `UFV_ASSERT_NOW(a_received_split, 1'b1,
      rsp_received_total == TOTAL_W'(rsp_good_total + rsp_bad_total),
      "received total differs from good plus bad")
   `UFV_ASSERT_NOW(a_bad_split, 1'b1,
      rsp_bad_total == TOTAL_W'(rsp_bad_length_total + rsp_bad_checksum_total),
      "bad total differs from its causes")
   // A rejected frame never reports a padded length.
   `UFV_ASSERT_NOW(a_reject_no_pad,
      rsp_valid && (verdict == VERDICT_BAD_LENGTH || verdict == VERDICT_LEN_MISMATCH ||
                    verdict == VERDICT_BAD_CHECKSUM),
      rsp_padded_length == '0, "rejected frame has a padded length")
   // A frame summary is never offered to a full queue.
   `UFV_ASSERT_NOW(a_no_overflow, push, !queue_status.full,
      "frame summary pushed into a full queue")
   // Once a summary is queued, the result register sees a valid head next.
   `UFV_ASSERT_NEXT(a_push_visible, push, queue_status.head_valid || rsp_valid,
      "queued summary went missing")

endmodule

### sv/ufv_front.sv
// Front end of the frame validator: takes frame bytes, folds the XOR, and
// pushes one summary per frame. Depends on ufv_pkg.
module ufv_front import ufv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic                preamble_valid,
   output logic                push,
   output frame_sum_type       push_data
);

   logic [LEN_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       low_byte_hold_ff, low_byte_hold_in;
   logic [15:0]      word_xor_ff, word_xor_in;
   logic [LEN_W-1:0] limit;
   logic             keep;
   logic [LEN_W-1:0] count_next;
   logic [7:0]       hold_next;
   logic [15:0]      xor_next;

   assign limit = eff_limit(cfg.payload_limit);
   assign keep  = byte_count_ff < limit;

   always_comb begin
      count_next = byte_count_ff;
      hold_next  = low_byte_hold_ff;
      xor_next   = word_xor_ff;
      if (keep) begin
         if (!byte_count_ff[0]) begin
            hold_next = data_byte;
         end else begin
            xor_next = word_xor_ff ^ {data_byte, low_byte_hold_ff};
         end
         count_next = byte_count_ff + LEN_W'(1);
      end
   end

   // The per-frame state clears once the final byte has been summarized.
   always_comb begin
      byte_count_in    = byte_count_ff;
      low_byte_hold_in = low_byte_hold_ff;
      word_xor_in      = word_xor_ff;
      if (accept) begin
         if (last_byte) begin
            byte_count_in    = '0;
            low_byte_hold_in = '0;
            word_xor_in      = '0;
         end else begin
            byte_count_in    = count_next;
            low_byte_hold_in = hold_next;
            word_xor_in      = xor_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         low_byte_hold_ff <= '0;
         word_xor_ff      <= '0;
      end else begin
         byte_count_ff    <= byte_count_in;
         low_byte_hold_ff <= low_byte_hold_in;
         word_xor_ff      <= word_xor_in;
      end
   end

   assign push                   = accept && last_byte;
   assign push_data.frame_length = count_next;
   assign push_data.xor_zero     = (xor_next == 16'h0000);
   assign push_data.preamble     = preamble_valid;

endmodule

### sv/ufv_queue.sv
// Small register queue of frame summaries between front and back.
// Depends on ufv_pkg.
module ufv_queue import ufv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_sum_type    push_data,
   input  logic             pop,
   output frame_sum_type    head,
   output queue_status_type status
);

   frame_sum_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign status.full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.head_valid = (fill_ff != '0);
   assign do_push           = push && !status.full;
   assign do_pop            = pop && status.head_valid;
   assign head              = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/ufv_back.sv
// Back end of the frame validator: judges frame summaries, keeps the
// counters and holds the result register. Depends on ufv_pkg.
module ufv_back import ufv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  frame_sum_type      head,
   input  logic               head_valid,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output verdict_type        verdict,
   output logic [LEN_W-1:0]   frame_length,
   output logic [LEN_W-1:0]   padded_length,
   output logic [TOTAL_W-1:0] received_total,
   output logic [TOTAL_W-1:0] good_total,
   output logic [TOTAL_W-1:0] bad_total,
   output logic [TOTAL_W-1:0] bad_length_total,
   output logic [TOTAL_W-1:0] bad_checksum_total
);

   logic                rsp_valid_ff;
   verdict_type         verdict_ff, verdict_in;
   logic [LEN_W-1:0]    frame_length_ff;
   logic [LEN_W-1:0]    padded_ff, padded_in;
   logic [COUNT_W-1:0]  received_ff, good_ff, bad_ff, bad_length_ff, bad_checksum_ff;
   logic [LEN_W-1:0]    limit;
   logic [LEN_W:0]      rounded;
   logic [LEN_W-1:0]    len;
   logic                load;

   assign load  = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop   = load;
   assign len   = head.frame_length;
   assign limit = eff_limit(cfg.payload_limit);

   always_comb begin
      rounded = ({1'b0, len} + (LEN_W+1)'(PAD_UNIT - 1)) & ~((LEN_W+1)'(PAD_UNIT - 1));
      if (rounded > {1'b0, limit}) begin
         padded_in = (len > limit) ? len : limit;
      end else begin
         padded_in = rounded[LEN_W-1:0];
      end
      if (!head.preamble) begin
         verdict_in = VERDICT_NO_PREAMBLE;
      end else if (!cfg.check_enable) begin
         verdict_in = VERDICT_GOOD_UNCHECKED;
      end else if (len[0] || len <= LEN_W'(WORD_BYTES)) begin
         verdict_in = VERDICT_BAD_LENGTH;
      end else if (len != cfg.expected_length) begin
         verdict_in = VERDICT_LEN_MISMATCH;
      end else if (!head.xor_zero) begin
         verdict_in = VERDICT_BAD_CHECKSUM;
      end else begin
         verdict_in = VERDICT_GOOD_CHECKED;
      end
      if (verdict_in inside {VERDICT_BAD_LENGTH, VERDICT_LEN_MISMATCH,
                             VERDICT_BAD_CHECKSUM}) begin
         padded_in = '0;
      end
   end

   // Counters move only when a result is loaded, so the result register
   // can show them directly while it waits for the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         received_ff     <= '0;
         good_ff         <= '0;
         bad_ff          <= '0;
         bad_length_ff   <= '0;
         bad_checksum_ff <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            if (head.preamble) begin
               received_ff <= received_ff + COUNT_W'(1);
            end
            case (verdict_in)
               VERDICT_GOOD_CHECKED, VERDICT_GOOD_UNCHECKED: begin
                  good_ff <= good_ff + COUNT_W'(1);
               end
               VERDICT_BAD_LENGTH, VERDICT_LEN_MISMATCH: begin
                  bad_ff        <= bad_ff + COUNT_W'(1);
                  bad_length_ff <= bad_length_ff + COUNT_W'(1);
               end
               VERDICT_BAD_CHECKSUM: begin
                  bad_ff          <= bad_ff + COUNT_W'(1);
                  bad_checksum_ff <= bad_checksum_ff + COUNT_W'(1);
               end
               default: begin
               end
            endcase
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff      <= verdict_in;
         frame_length_ff <= len;
         padded_ff       <= padded_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign verdict            = verdict_ff;
   assign frame_length       = frame_length_ff;
   assign padded_length      = padded_ff;
   assign received_total     = TOTAL_W'(received_ff);
   assign good_total         = TOTAL_W'(good_ff);
   assign bad_total          = TOTAL_W'(bad_ff);
   assign bad_length_total   = TOTAL_W'(bad_length_ff);
   assign bad_checksum_total = TOTAL_W'(bad_checksum_ff);

endmodule

### bench/uplink_frame_validator_test.sv
// Self-checking bench for uplink_frame_validator: streams frame bytes, models the
// running XOR, lengths and counters, and compares every verdict item.
// Depends on ufv_pkg and the uplink_frame_validator RTL only.
module uplink_frame_validator_test;
   import ufv_pkg::*;

   // One frame byte as it travels on the req_ channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       preamble;
   } frame_byte_type;

   // One verdict item as it should appear on the rsp_ channel.
   typedef struct {
      verdict_type        verdict;
      logic [LEN_W-1:0]   frame_length;
      logic [LEN_W-1:0]   padded_length;
      logic [TOTAL_W-1:0] received;
      logic [TOTAL_W-1:0] good;
      logic [TOTAL_W-1:0] bad;
      logic [TOTAL_W-1:0] bad_length;
      logic [TOTAL_W-1:0] bad_checksum;
   } verdict_rec_type;

   // Register settings and stimulus shape of one phase of the run.
   typedef struct {
      bit          enable;
      int unsigned expected;
      int unsigned limit;
      int unsigned budget;
      bit          idle;
      bit          pressure;
      bit          force_good;
   } phase_type;

   localparam int unsigned PHASE_COUNT  = 11;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned PRINT_LIMIT  = 100;
   localparam logic [1:0]  UNUSED_REG_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = '0;
   logic               req_last_byte = 1'b0;
   logic               req_preamble_valid = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_verdict;
   logic [LEN_W-1:0]   rsp_frame_length;
   logic [LEN_W-1:0]   rsp_padded_length;
   logic [TOTAL_W-1:0] rsp_received_total;
   logic [TOTAL_W-1:0] rsp_good_total;
   logic [TOTAL_W-1:0] rsp_bad_total;
   logic [TOTAL_W-1:0] rsp_bad_length_total;
   logic [TOTAL_W-1:0] rsp_bad_checksum_total;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   uplink_frame_validator uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .req_preamble_valid     (req_preamble_valid),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_verdict            (rsp_verdict),
      .rsp_frame_length       (rsp_frame_length),
      .rsp_padded_length      (rsp_padded_length),
      .rsp_received_total     (rsp_received_total),
      .rsp_good_total         (rsp_good_total),
      .rsp_bad_total          (rsp_bad_total),
      .rsp_bad_length_total   (rsp_bad_length_total),
      .rsp_bad_checksum_total (rsp_bad_checksum_total),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the three registers, updated when a write lands.
   logic             cfg_enable   = 1'b1;
   logic [LEN_W-1:0] cfg_expected = RESET_EXPECTED_LENGTH;
   logic [LEN_W-1:0] cfg_limit    = RESET_PAYLOAD_LIMIT;

   // Per-frame state of the checksum model and the wrapping frame counters.
   logic [LEN_W-1:0]   kept_bytes    = '0;
   logic [7:0]         held_low_byte = '0;
   logic [15:0]        run_xor       = '0;
   logic [TOTAL_W-1:0] received_frames     = '0;
   logic [TOTAL_W-1:0] good_frames         = '0;
   logic [TOTAL_W-1:0] bad_frames          = '0;
   logic [TOTAL_W-1:0] bad_length_frames   = '0;
   logic [TOTAL_W-1:0] bad_checksum_frames = '0;

   frame_byte_type  pending_bytes [$];
   verdict_rec_type verdicts_due [$];

   int unsigned bytes_queued     = 0;
   int unsigned bytes_accepted   = 0;
   int unsigned verdicts_checked = 0;
   int unsigned mismatch_count   = 0;

   // Idling and back-pressure controls, owned by the sequencing block.
   logic           idle_enable   = 1'b1;
   int unsigned    hold_requests = 0;
   int unsigned    holds_served  = 0;
   int unsigned    hold_left     = 0;
   int unsigned    send_gap      = 0;
   int unsigned    stall_gap     = 0;
   int unsigned    quiet_cycles  = 0;
   frame_byte_type offered       = '0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("MISMATCH %s: got %0d, want %0d (verdict item %0d)",
                  what, got, want, verdicts_checked);
      mismatch_count++;
   endtask

   // Folds one accepted byte into the frame state. On the final byte the
   // verdict is worked out in priority order and queued as an expectation,
   // and the per-frame state starts over.
   task automatic fold_byte(input frame_byte_type b);
      int unsigned     lim;
      int unsigned     len;
      int unsigned     padded;
      verdict_rec_type v;
      lim = (cfg_limit > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : cfg_limit;
      // Bytes past the limit are dropped; an unpaired byte never reaches the XOR.
      if (kept_bytes < lim) begin
         if (!kept_bytes[0]) begin
            held_low_byte = b.data;
         end else begin
            run_xor = run_xor ^ {b.data, held_low_byte};
         end
         kept_bytes = kept_bytes + 1'b1;
      end
      if (b.last) begin
         len = kept_bytes;
         padded = (len + PAD_UNIT - 1) & ~(PAD_UNIT - 1);
         if (padded > lim) padded = (len > lim) ? len : lim;
         if (!b.preamble) begin
            // A frame with no preamble moves no counter but still reports lengths.
            v.verdict = VERDICT_NO_PREAMBLE;
         end else begin
            received_frames = received_frames + 1'b1;
            if (!cfg_enable) begin
               v.verdict = VERDICT_GOOD_UNCHECKED;
               good_frames = good_frames + 1'b1;
            end else if (len[0] || len <= WORD_BYTES) begin
               v.verdict = VERDICT_BAD_LENGTH;
            end else if (len != cfg_expected) begin
               v.verdict = VERDICT_LEN_MISMATCH;
            end else if (run_xor != 16'h0000) begin
               v.verdict = VERDICT_BAD_CHECKSUM;
            end else begin
               v.verdict = VERDICT_GOOD_CHECKED;
               good_frames = good_frames + 1'b1;
            end
            if (v.verdict == VERDICT_BAD_LENGTH || v.verdict == VERDICT_LEN_MISMATCH ||
                v.verdict == VERDICT_BAD_CHECKSUM) begin
               bad_frames = bad_frames + 1'b1;
               if (v.verdict == VERDICT_BAD_CHECKSUM) begin
                  bad_checksum_frames = bad_checksum_frames + 1'b1;
               end else begin
                  bad_length_frames = bad_length_frames + 1'b1;
               end
               padded = 0;
            end
         end
         v.frame_length  = LEN_W'(len);
         v.padded_length = LEN_W'(padded);
         v.received      = received_frames;
         v.good          = good_frames;
         v.bad           = bad_frames;
         v.bad_length    = bad_length_frames;
         v.bad_checksum  = bad_checksum_frames;
         verdicts_due.push_back(v);
         kept_bytes    = '0;
         held_low_byte = '0;
         run_xor       = '0;
      end
   endtask

   // Sender. An item is accepted at an edge where valid is high and stall is
   // low; only then, or while valid is low, may the next item or an idle
   // burst be chosen, so a stalled item always holds steady.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_byte(offered);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               offered = pending_bytes.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= offered.data;
               req_last_byte      <= offered.last;
               req_preamble_valid <= offered.preamble;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off. Each new request from the sequencing block
   // starts one long stretch of receiver stalls, counted down in hold_left.
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
      end
   end

   // Receiver. Checks every accepted verdict item against the oldest
   // expectation, then picks the stall for the next cycle.
   always @(posedge clock) begin
      verdict_rec_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch("verdict item with nothing pending", rsp_verdict, 0);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict)
                  report_mismatch("verdict", rsp_verdict, want.verdict);
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_frame_length, want.frame_length);
               if (rsp_padded_length !== want.padded_length)
                  report_mismatch("padded_length", rsp_padded_length, want.padded_length);
               if (rsp_received_total !== want.received)
                  report_mismatch("received_total", rsp_received_total, want.received);
               if (rsp_good_total !== want.good)
                  report_mismatch("good_total", rsp_good_total, want.good);
               if (rsp_bad_total !== want.bad)
                  report_mismatch("bad_total", rsp_bad_total, want.bad);
               if (rsp_bad_length_total !== want.bad_length)
                  report_mismatch("bad_length_total", rsp_bad_length_total,
                                  want.bad_length);
               if (rsp_bad_checksum_total !== want.bad_checksum)
                  report_mismatch("bad_checksum_total", rsp_bad_checksum_total,
                                  want.bad_checksum);
            end
            verdicts_checked++;
         end
         if (stall_gap != 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_gap = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (hold_left != 0);
         end
      end
   end

   // Watchdog: too many cycles in a row with no item accepted on either
   // channel means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic last, input logic pre);
      frame_byte_type b;
      b.data     = data;
      b.last     = last;
      b.preamble = pre;
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Queues one frame of total bytes with random content. When asked, the
   // word ending at the kept length is set so that the XOR of the kept words
   // is zero; a spoiled frame then gets one bit flipped inside the kept part.
   task automatic queue_frame(input int unsigned total, input int unsigned kept,
                              input bit fix_sum, input bit spoil, input bit pre);
      logic [7:0]  frame_bytes [$];
      logic [15:0] acc;
      int unsigned i;
      frame_bytes.delete();
      for (i = 0; i < total; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (fix_sum && kept >= WORD_BYTES && !kept[0]) begin
         acc = '0;
         for (i = 0; i + WORD_BYTES < kept; i += WORD_BYTES)
            acc = acc ^ {frame_bytes[i+1], frame_bytes[i]};
         frame_bytes[kept-2] = acc[7:0];
         frame_bytes[kept-1] = acc[15:8];
      end
      if (spoil && kept != 0)
         frame_bytes[$urandom_range(0, kept - 1)] ^= 8'(1 << $urandom_range(0, 7));
      for (i = 0; i < total; i++)
         push_byte(frame_bytes[i], i == total - 1,
                   (i == total - 1) ? pre : 1'($urandom_range(0, 1)));
   endtask

   // Most frames are well formed for the current settings, with a preamble,
   // the expected length and a correct checksum word, so that they pass every
   // check unless a bit is spoiled; the rest are short or near-length noise.
   task automatic queue_random_frame(input phase_type ph);
      int unsigned lim;
      int unsigned total;
      int unsigned kept;
      int unsigned upper;
      bit          tidy;
      lim  = (ph.limit > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : ph.limit;
      tidy = ph.force_good || ($urandom_range(0, 9) < 7);
      if (tidy && (!ph.enable || (!ph.expected[0] && ph.expected > WORD_BYTES &&
                                  ph.expected <= lim))) begin
         kept  = ph.enable ? ph.expected : $urandom_range(1, 48);
         if (kept > lim) kept = lim;
         // A frame as long as the limit may carry up to three extra bytes to be dropped.
         total = (kept == lim) ? kept + $urandom_range(0, 3) : kept;
         if (total == 0) total = 1;
         queue_frame(total, kept, 1'b1, !ph.force_good && $urandom_range(0, 6) == 0, 1'b1);
      end else begin
         upper = (ph.expected + 2 < lim + 3) ? ph.expected + 2 : lim + 3;
         if ($urandom_range(0, 1) == 0) begin
            total = $urandom_range(1, 12);
         end else begin
            total = $urandom_range((upper > 4) ? upper - 4 : 1, upper);
         end
         kept = (total < lim) ? total : lim;
         queue_frame(total, kept, 1'($urandom_range(0, 1)), 1'b0,
                     $urandom_range(0, 4) != 0);
      end
   endtask

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the edge where the access phase meets pready.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_CHECK_ENABLE:    cfg_enable   = value[0];
         REG_EXPECTED_LENGTH: cfg_expected = value[LEN_W-1:0];
         REG_PAYLOAD_LIMIT:   cfg_limit    = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every queued byte is taken and every verdict has come, then
   // gives the back end of the block time to settle.
   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Settings for each random phase. The list runs through checks off, the
   // reset values, the largest frame with a saturating limit, limits of 8, 0
   // and odd 7, an expected length no frame can reach, back-pressure without
   // idling, an odd limit 13, checks off again and a last idle-free phase.
   function automatic phase_type phase_plan(input int unsigned idx);
      phase_type ph;
      ph = '{enable: 1'b1, expected: 86, limit: 256, budget: 150,
             idle: 1'b1, pressure: 1'b0, force_good: 1'b0};
      case (idx)
         0:  begin ph.enable = 1'b0; ph.budget = 100; end
         1:  ph.budget = 150;
         2:  begin ph.expected = 1024; ph.limit = 2047; ph.budget = 1; ph.force_good = 1'b1; end
         3:  begin ph.expected = 8; ph.limit = 8; ph.budget = 80; end
         4:  begin ph.expected = 0; ph.limit = 0; ph.budget = 40; end
         5:  begin ph.expected = 7; ph.limit = 7; ph.budget = 60; end
         6:  begin ph.expected = 2047; ph.limit = 64; ph.budget = 50; end
         7:  begin ph.expected = 6; ph.limit = 8; ph.budget = 150;
                   ph.idle = 1'b0; ph.pressure = 1'b1; end
         8:  begin ph.expected = 12; ph.limit = 13; ph.budget = 100; end
         9:  begin ph.enable = 1'b0; ph.expected = 20; ph.limit = 1024; ph.budget = 60; end
         default: begin ph.expected = 16; ph.limit = 24; ph.budget = 150; ph.idle = 1'b0; end
      endcase
      return ph;
   endfunction

   initial begin
      phase_type   ph;
      int unsigned p;
      int unsigned phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset settings: a lone byte with no
      // preamble, a frame too short to hold a checksum, an odd length, and
      // a length that differs from the expected one.
      push_byte(8'hA5, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b1);
      push_byte(8'h01, 1'b0, 1'b1);
      push_byte(8'h02, 1'b0, 1'b0);
      push_byte(8'h03, 1'b1, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b1);
      wait_drained();

      // With a six-byte expected length: one frame whose trailing word
      // cancels the XOR of the words before it, and one whose does not.
      csr_write(REG_EXPECTED_LENGTH, 32'd6);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b1);
      push_byte(8'h12, 1'b0, 1'b0);
      push_byte(8'h34, 1'b0, 1'b0);
      push_byte(8'h56, 1'b0, 1'b1);
      push_byte(8'h78, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h00, 1'b1, 1'b1);
      wait_drained();

      for (p = 0; p < PHASE_COUNT; p++) begin
         ph = phase_plan(p);
         idle_enable <= ph.idle;
         // Upper bits of each write are random; the block keeps only the
         // register's own width.
         csr_write(REG_CHECK_ENABLE, ($urandom & ~32'h1) | 32'(ph.enable));
         csr_write(REG_EXPECTED_LENGTH, ($urandom & ~32'h7FF) | ph.expected);
         csr_write(REG_PAYLOAD_LIMIT, ($urandom & ~32'h7FF) | ph.limit);
         // A write past the last register must leave the settings alone.
         if (p == 4) csr_write(UNUSED_REG_INDEX, $urandom);
         // The receiver stalls for a long stretch while short frames keep
         // coming, so the summary queue fills and the input stalls.
         if (ph.pressure) hold_requests <= hold_requests + 1;
         phase_start = bytes_queued;
         do queue_random_frame(ph); while (bytes_queued - phase_start < ph.budget);
         wait_drained();
      end

      $display("Sent %0d frame bytes and checked %0d verdict items across %0d settings.",
               bytes_accepted, verdicts_checked, PHASE_COUNT + 2);
      $display("Field mismatches found: %0d.", mismatch_count);
      if (mismatch_count == 0 && verdicts_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
